>>> design/msgstat_pkg.sv
`timescale 1ns / 1ps

package msgstat_pkg;

    // Table and counter sizing
    localparam int NEIGHBORS  = 16;
    localparam int COUNT_BITS = 32;
    localparam int SLOT_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int NUM_GLOBAL = 22;
    localparam int GIDX_W     = 5;
    localparam int BYTES_W    = 17;
    localparam int SUM_W      = ((COUNT_BITS > BYTES_W) ? COUNT_BITS : BYTES_W) + 1;
    localparam int WIDE_W     = COUNT_BITS + 32;
    localparam int NBR_W      = 3 * COUNT_BITS;
    localparam int STEP_W     = 3;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [GIDX_W-1:0]     gidx_t;
    typedef logic [BYTES_W-1:0]    bytes_t;
    typedef logic [STEP_W-1:0]     step_t;

    localparam step_t LAST_STEP = step_t'(5);

    typedef enum logic [1:0] {
        OP_LOG_RECV      = 2'd0,
        OP_LOG_SEND      = 2'd1,
        OP_READ_GLOBAL   = 2'd2,
        OP_READ_NEIGHBOR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_LOCAL_ADDRESS     = 2'd0,
        REG_BROADCAST_ADDRESS = 2'd1,
        REG_HEADER_BYTES      = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BUMP,
        ST_DONE
    } state_t;

    // Global layout: even receive, odd send; reversed from IDX_NEW on
    localparam gidx_t IDX_BYTES              = gidx_t'(0);
    localparam gidx_t IDX_PACKETS            = gidx_t'(2);
    localparam gidx_t IDX_BCAST_BYTES        = gidx_t'(4);
    localparam gidx_t IDX_BCAST_PACKETS      = gidx_t'(6);
    localparam gidx_t IDX_BCAST_PACKETS_SENT = gidx_t'(7);
    localparam gidx_t IDX_NEW                = gidx_t'(8);
    localparam gidx_t IDX_OLD                = gidx_t'(10);
    localparam gidx_t IDX_KIND               = gidx_t'(12);

    localparam logic [2:0] KIND_LAST = 3'd4;

    // Neighbor table lookup result
    typedef struct packed {
        logic  hit;
        logic  full;
        slot_t hit_slot;
        slot_t free_slot;
    } nbr_lookup_t;

    // Neighbor table insert command
    typedef struct packed {
        logic        en;
        slot_t       slot;
        logic [31:0] address;
    } nbr_insert_t;

    // Saturating add of a byte or packet amount
    function automatic count_t sat_add_bytes(count_t a, bytes_t b);
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] lim;
        sum = SUM_W'(a) + SUM_W'(b);
        lim = SUM_W'({COUNT_BITS{1'b1}});
        return (sum > lim) ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    // Saturating add of two counters
    function automatic count_t sat_add_count(count_t a, count_t b);
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
    endfunction

    // Clamp a counter to the 32-bit result field
    function automatic logic [31:0] clamp_out(count_t v);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(v);
        return (wide > WIDE_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    // Counter touched by one step of a log event
    function automatic gidx_t bump_index(step_t step, logic send, logic is_new,
                                         logic [2:0] kind);
        gidx_t snd;
        gidx_t rcv;
        gidx_t idx;
        snd = gidx_t'(send);
        rcv = gidx_t'(!send);
        case (step)
            step_t'(0): idx = IDX_BYTES + snd;
            step_t'(1): idx = IDX_PACKETS + snd;
            step_t'(2): idx = IDX_BCAST_BYTES + snd;
            step_t'(3): idx = IDX_BCAST_PACKETS + snd;
            step_t'(4): idx = (is_new ? IDX_NEW : IDX_OLD) + rcv;
            step_t'(5): idx = (kind > KIND_LAST) ? IDX_BYTES
                                                 : IDX_KIND + gidx_t'({kind, 1'b0}) + rcv;
            default:    idx = IDX_BYTES;
        endcase
        return idx;
    endfunction

    // Whether a step of a log event changes its counter
    function automatic logic bump_enable(step_t step, logic bcast, logic [2:0] kind);
        logic en;
        case (step)
            step_t'(2), step_t'(3): en = bcast;
            step_t'(5):             en = (kind <= KIND_LAST);
            default:                en = 1'b1;
        endcase
        return en;
    endfunction

    // Byte counters add the message length, the others add one
    function automatic logic bump_uses_bytes(step_t step);
        return (step == step_t'(0)) || (step == step_t'(2));
    endfunction

endpackage

>>> design/msgstat_ram.sv
`timescale 1ns / 1ps

module msgstat_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/msgstat_nbr_table.sv
`timescale 1ns / 1ps

module msgstat_nbr_table
    import msgstat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] key,
    input  nbr_insert_t insert,
    input  slot_t       rd_slot,
    output nbr_lookup_t lookup,
    output logic        rd_valid,
    output logic [31:0] rd_address
);

    logic [NEIGHBORS-1:0] valid_reg;
    logic [31:0]          addr_reg [NEIGHBORS];

    // Valid bits, set on insert
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (insert.en)
        begin
            valid_reg[insert.slot] <= 1'b1;
        end
    end

    // Neighbor addresses
    always_ff @(posedge clk)
    begin
        if (insert.en)
        begin
            addr_reg[insert.slot] <= insert.address;
        end
    end

    // Match key against every entry, find lowest free slot
    always_comb
    begin
        lookup = '0;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (valid_reg[i] && (addr_reg[i] == key))
            begin
                lookup.hit      = 1'b1;
                lookup.hit_slot = lookup.hit_slot | slot_t'(i);
            end
        end
        for (int i = NEIGHBORS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                lookup.free_slot = slot_t'(i);
            end
        end
        lookup.full = &valid_reg;
    end

    // Slot read for neighbor reports
    assign rd_valid   = valid_reg[rd_slot];
    assign rd_address = addr_reg[rd_slot];

endmodule

>>> design/message_traffic_statistics.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// config    cfg_write                 cfg_index, cfg_data
// events    in_valid / in_ready       operation .. neighbor_slot
// results   out_valid / out_ready     read_value .. table_full_drop
//
// A log event runs from the start state through six read-modify-write passes
// over the global counter memory in the bump state, one counter per cycle through
// its single write port, then the done state, which loads the result register.
// Reads and local-source receives go from the start state straight to done.
// Reset clears valid bits, not the counter memory, which needs no clearing pass.
// A new event is taken while the previous result waits in the output
// register; a finished event holds in its last state until that register frees.

module message_traffic_statistics
    import msgstat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] previous_hop,
    input  logic [31:0] following_hop,
    input  logic [15:0] payload_bytes,
    input  logic        is_new,
    input  logic [2:0]  message_kind,
    input  logic [4:0]  counter_select,
    input  logic [3:0]  neighbor_slot,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_value,
    output logic        entry_valid,
    output logic [31:0] entry_address,
    output logic [31:0] sent_unicast,
    output logic [31:0] sent_total,
    output logic [31:0] recv_unicast,
    output logic [31:0] recv_broadcast,
    output logic [31:0] recv_total,
    output logic        was_counted,
    output logic        table_full_drop
);

    // Configuration
    logic [31:0] local_address_reg;
    logic [31:0] broadcast_address_reg;
    logic [7:0]  header_bytes_reg;

    // Sequencer
    state_t state_reg;
    state_t state_next;
    step_t  step_reg;
    step_t  step_next;
    step_t  step_inc;

    // Captured event
    op_t         op_reg;
    logic [31:0] prev_reg;
    logic [31:0] next_reg;
    bytes_t      bytes_reg;
    logic        new_reg;
    logic [2:0]  kind_reg;
    gidx_t       sel_reg;
    logic [3:0]  slot_reg;

    // Event decisions
    logic  bcast_reg;
    logic  touch_reg;
    logic  hit_reg;
    logic  full_reg;
    slot_t nslot_reg;
    logic  counted_reg;
    logic  drop_reg;

    logic  bcast_now;
    logic  is_local;
    logic  touch_now;
    logic  is_log;
    logic  sel_ok;
    logic  slot_ok;
    slot_t rd_slot_idx;

    // Global counter memory
    logic [NUM_GLOBAL-1:0] gval_reg;
    gidx_t                 g_rd_addr_reg;
    logic                  g_rd_en;
    gidx_t                 g_rd_addr;
    logic                  g_wr_en;
    gidx_t                 g_wr_addr;
    count_t                g_wr_data;
    count_t                g_rd_data;
    count_t                g_cur;

    // Neighbor counter memory
    logic             n_rd_en;
    slot_t            n_rd_addr;
    logic             n_wr_en;
    logic [NBR_W-1:0] n_wr_data;
    logic [NBR_W-1:0] n_rd_data;
    logic [NBR_W-1:0] n_cur;
    count_t           n_sent;
    count_t           n_recv;
    count_t           n_recvb;

    // Neighbor address table
    logic [31:0] key;
    nbr_lookup_t lookup;
    nbr_insert_t ins;
    logic        tab_rd_valid;
    logic [31:0] tab_rd_address;

    // Control
    logic item_load;
    logic start_load;
    logic out_load;

    // Output register
    logic        out_valid_reg;
    logic [31:0] read_value_reg;
    logic        entry_valid_reg;
    logic [31:0] entry_address_reg;
    logic [31:0] sent_unicast_reg;
    logic [31:0] sent_total_reg;
    logic [31:0] recv_unicast_reg;
    logic [31:0] recv_broadcast_reg;
    logic [31:0] recv_total_reg;
    logic        was_counted_reg;
    logic        table_full_drop_reg;

    logic [31:0] read_value_next;
    logic        entry_valid_next;
    logic [31:0] entry_address_next;
    logic [31:0] sent_unicast_next;
    logic [31:0] sent_total_next;
    logic [31:0] recv_unicast_next;
    logic [31:0] recv_broadcast_next;
    logic [31:0] recv_total_next;
    logic        was_counted_next;
    logic        table_full_drop_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg     <= 32'hFFFF_FFFE;
            broadcast_address_reg <= 32'hFFFF_FFFF;
            header_bytes_reg      <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_LOCAL_ADDRESS:     local_address_reg     <= cfg_data;
                REG_BROADCAST_ADDRESS: broadcast_address_reg <= cfg_data;
                REG_HEADER_BYTES:      header_bytes_reg      <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    // Event decode
    assign is_log      = (op_reg == OP_LOG_RECV) || (op_reg == OP_LOG_SEND);
    assign bcast_now   = (next_reg == broadcast_address_reg);
    assign is_local    = (op_reg == OP_LOG_RECV) && (prev_reg == local_address_reg);
    assign touch_now   = (op_reg == OP_LOG_RECV) || !bcast_now;
    assign key         = (op_reg == OP_LOG_RECV) ? prev_reg : next_reg;
    assign sel_ok      = int'(sel_reg) < NUM_GLOBAL;
    assign slot_ok     = int'(slot_reg) < NEIGHBORS;
    assign rd_slot_idx = slot_ok ? slot_t'(slot_reg) : '0;
    assign step_inc    = step_reg + step_t'(1);
    assign n_rd_addr   = (op_reg == OP_READ_NEIGHBOR) ? rd_slot_idx : lookup.hit_slot;

    // Current global counter, zero until first written
    assign g_cur = gval_reg[g_rd_addr_reg] ? g_rd_data : '0;

    // Neighbor counters, zero for a fresh entry
    assign n_cur   = (op_reg == OP_READ_NEIGHBOR || hit_reg) ? n_rd_data : '0;
    assign n_sent  = n_cur[3*COUNT_BITS-1:2*COUNT_BITS];
    assign n_recv  = n_cur[2*COUNT_BITS-1:COUNT_BITS];
    assign n_recvb = n_cur[COUNT_BITS-1:0];

    // Neighbor update
    always_comb
    begin
        if (op_reg == OP_LOG_RECV)
        begin
            n_wr_data = {n_sent,
                         sat_add_bytes(n_recv, bytes_t'(1)),
                         sat_add_bytes(n_recvb, bytes_t'(bcast_reg))};
        end
        else
        begin
            n_wr_data = {sat_add_bytes(n_sent, bytes_t'(1)), n_recv, n_recvb};
        end
    end

    // Next state and memory control
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_ready    = 1'b0;
        item_load   = 1'b0;
        start_load  = 1'b0;
        out_load    = 1'b0;
        g_rd_en     = 1'b0;
        g_rd_addr   = IDX_BYTES;
        g_wr_en     = 1'b0;
        g_wr_addr   = bump_index(step_reg, op_reg == OP_LOG_SEND, new_reg, kind_reg);
        g_wr_data   = sat_add_bytes(g_cur,
                                    bump_uses_bytes(step_reg) ? bytes_reg : bytes_t'(1));
        n_rd_en     = 1'b0;
        n_wr_en     = 1'b0;
        ins         = '0;
        ins.slot    = nslot_reg;
        ins.address = key;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_load  = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                start_load = 1'b1;
                step_next  = '0;
                case (op_reg)
                    OP_LOG_RECV, OP_LOG_SEND:
                    begin
                        if (is_local)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            g_rd_en    = 1'b1;
                            g_rd_addr  = bump_index('0, op_reg == OP_LOG_SEND,
                                                    new_reg, kind_reg);
                            n_rd_en    = 1'b1;
                            state_next = ST_BUMP;
                        end
                    end
                    OP_READ_GLOBAL:
                    begin
                        g_rd_en    = 1'b1;
                        g_rd_addr  = sel_ok ? sel_reg : IDX_BYTES;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        g_rd_en    = 1'b1;
                        g_rd_addr  = IDX_BCAST_PACKETS_SENT;
                        n_rd_en    = 1'b1;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_BUMP:
            begin
                g_wr_en = bump_enable(step_reg, bcast_reg, kind_reg);
                if (step_reg == '0)
                begin
                    n_wr_en = touch_reg && (hit_reg || !full_reg);
                    ins.en  = touch_reg && !hit_reg && !full_reg;
                end
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_inc;
                    g_rd_en   = 1'b1;
                    g_rd_addr = bump_index(step_inc, op_reg == OP_LOG_SEND,
                                           new_reg, kind_reg);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture event on transfer
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            op_reg    <= op_t'(operation);
            prev_reg  <= previous_hop;
            next_reg  <= following_hop;
            bytes_reg <= bytes_t'(payload_bytes) + bytes_t'(header_bytes_reg);
            new_reg   <= is_new;
            kind_reg  <= message_kind;
            sel_reg   <= counter_select;
            slot_reg  <= neighbor_slot;
        end
    end

    // Latch lookup and event decisions
    always_ff @(posedge clk)
    begin
        if (start_load)
        begin
            bcast_reg   <= bcast_now;
            touch_reg   <= touch_now;
            hit_reg     <= lookup.hit;
            full_reg    <= lookup.full;
            nslot_reg   <= lookup.hit ? lookup.hit_slot : lookup.free_slot;
            counted_reg <= is_log && !is_local;
            drop_reg    <= is_log && !is_local && touch_now && !lookup.hit && lookup.full;
        end
    end

    // Global counter valid bits and read address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gval_reg <= '0;
        end
        else if (g_wr_en)
        begin
            gval_reg[g_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_rd_en)
        begin
            g_rd_addr_reg <= g_rd_addr;
        end
    end

    msgstat_ram
    #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_GLOBAL)
    )
    u_gram
    (
        .clk     (clk),
        .wr_en   (g_wr_en),
        .wr_addr (g_wr_addr),
        .wr_data (g_wr_data),
        .rd_en   (g_rd_en),
        .rd_addr (g_rd_addr),
        .rd_data (g_rd_data)
    );

    msgstat_ram
    #(
        .WIDTH (NBR_W),
        .DEPTH (NEIGHBORS)
    )
    u_nram
    (
        .clk     (clk),
        .wr_en   (n_wr_en),
        .wr_addr (nslot_reg),
        .wr_data (n_wr_data),
        .rd_en   (n_rd_en),
        .rd_addr (n_rd_addr),
        .rd_data (n_rd_data)
    );

    msgstat_nbr_table u_ntab
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .insert     (ins),
        .rd_slot    (rd_slot_idx),
        .lookup     (lookup),
        .rd_valid   (tab_rd_valid),
        .rd_address (tab_rd_address)
    );

    // Build result fields
    always_comb
    begin
        read_value_next      = '0;
        entry_valid_next     = 1'b0;
        entry_address_next   = '0;
        sent_unicast_next    = '0;
        sent_total_next      = '0;
        recv_unicast_next    = '0;
        recv_broadcast_next  = '0;
        recv_total_next      = '0;
        was_counted_next     = 1'b0;
        table_full_drop_next = 1'b0;
        case (op_reg)
            OP_LOG_RECV, OP_LOG_SEND:
            begin
                was_counted_next     = counted_reg;
                table_full_drop_next = drop_reg;
            end
            OP_READ_GLOBAL:
            begin
                if (sel_ok)
                begin
                    read_value_next = clamp_out(g_cur);
                end
            end
            default:
            begin
                if (slot_ok && tab_rd_valid)
                begin
                    entry_valid_next    = 1'b1;
                    entry_address_next  = tab_rd_address;
                    sent_unicast_next   = clamp_out(n_sent);
                    sent_total_next     = clamp_out(sat_add_count(n_sent, g_cur));
                    recv_unicast_next   = clamp_out((n_recv >= n_recvb) ? n_recv - n_recvb
                                                                        : '0);
                    recv_broadcast_next = clamp_out(n_recvb);
                    recv_total_next     = clamp_out(n_recv);
                end
            end
        endcase
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_value_reg      <= read_value_next;
            entry_valid_reg     <= entry_valid_next;
            entry_address_reg   <= entry_address_next;
            sent_unicast_reg    <= sent_unicast_next;
            sent_total_reg      <= sent_total_next;
            recv_unicast_reg    <= recv_unicast_next;
            recv_broadcast_reg  <= recv_broadcast_next;
            recv_total_reg      <= recv_total_next;
            was_counted_reg     <= was_counted_next;
            table_full_drop_reg <= table_full_drop_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_value      = read_value_reg;
    assign entry_valid     = entry_valid_reg;
    assign entry_address   = entry_address_reg;
    assign sent_unicast    = sent_unicast_reg;
    assign sent_total      = sent_total_reg;
    assign recv_unicast    = recv_unicast_reg;
    assign recv_broadcast  = recv_broadcast_reg;
    assign recv_total      = recv_total_reg;
    assign was_counted     = was_counted_reg;
    assign table_full_drop = table_full_drop_reg;

endmodule

>>> bench/traffic_checker.sv
`timescale 1ns / 1ps

module traffic_checker
    import msgstat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] previous_hop,
    input  logic [31:0] following_hop,
    input  logic [15:0] payload_bytes,
    input  logic        is_new,
    input  logic [2:0]  message_kind,
    input  logic [4:0]  counter_select,
    input  logic [3:0]  neighbor_slot,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] read_value,
    input  logic        entry_valid,
    input  logic [31:0] entry_address,
    input  logic [31:0] sent_unicast,
    input  logic [31:0] sent_total,
    input  logic [31:0] recv_unicast,
    input  logic [31:0] recv_broadcast,
    input  logic [31:0] recv_total,
    input  logic        was_counted,
    input  logic        table_full_drop,
    output int          error_count,
    output int          awaiting,
    output int          table_fill
);

    // Global counter layout: receive and send counters sit side by side
    localparam int BASE_BYTES         = 0;
    localparam int BASE_PACKETS       = 2;
    localparam int BASE_BCAST_BYTES   = 4;
    localparam int BASE_BCAST_PACKETS = 6;
    localparam int BCAST_PACKETS_SENT = 7;
    localparam int BASE_NEW           = 8;
    localparam int BASE_OLD           = 10;
    localparam int BASE_KIND          = 12;
    localparam int LAST_KIND          = 4;

    localparam logic [31:0] LOCAL_RESET = 32'hFFFF_FFFE;
    localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] read_value;
        logic        entry_valid;
        logic [31:0] entry_address;
        logic [31:0] sent_unicast;
        logic [31:0] sent_total;
        logic [31:0] recv_unicast;
        logic [31:0] recv_broadcast;
        logic [31:0] recv_total;
        logic        was_counted;
        logic        table_full_drop;
    } report_t;

    report_t     report_q[$];

    // Shadow configuration
    logic [31:0] local_addr;
    logic [31:0] bcast_addr;
    logic [7:0]  hdr_bytes;

    // Shadow statistics
    count_t      glob_cnt [NUM_GLOBAL];
    logic [31:0] nbr_addr [NEIGHBORS];
    logic        nbr_used [NEIGHBORS];
    count_t      nbr_sent [NEIGHBORS];
    count_t      nbr_recv [NEIGHBORS];
    count_t      nbr_recv_bcast [NEIGHBORS];
    int          used_slots;

    // Saturating add at counter width
    function automatic count_t sat_sum(count_t a, logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return (s > 65'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}} : count_t'(s);
    endfunction

    // Clip a counter to the 32-bit result field
    function automatic logic [31:0] out_clip(count_t v);
        return (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void tally(int idx, logic [63:0] amount);
        if (idx < NUM_GLOBAL)
            glob_cnt[idx] = sat_sum(glob_cnt[idx], amount);
    endfunction

    // Update the global counters for one logged message
    function automatic void log_traffic(logic rx, logic [63:0] amount, logic bcast,
                                        logic fresh, logic [2:0] kind);
        int side;
        int dir;
        side = rx ? 0 : 1;
        dir  = rx ? 1 : 0;
        tally(BASE_BYTES + side, amount);
        tally(BASE_PACKETS + side, 64'd1);
        if (bcast)
        begin
            tally(BASE_BCAST_BYTES + side, amount);
            tally(BASE_BCAST_PACKETS + side, 64'd1);
        end
        tally((fresh ? BASE_NEW : BASE_OLD) + dir, 64'd1);
        if (int'(kind) <= LAST_KIND)
            tally(BASE_KIND + 2 * int'(kind) + dir, 64'd1);
    endfunction

    // Find a neighbor, taking the lowest free slot on a miss; -1 when full
    function automatic int claim_slot(logic [31:0] addr);
        for (int i = 0; i < NEIGHBORS; i++)
            if (nbr_used[i] && nbr_addr[i] == addr)
                return i;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (!nbr_used[i])
            begin
                nbr_used[i]       = 1'b1;
                nbr_addr[i]       = addr;
                nbr_sent[i]       = '0;
                nbr_recv[i]       = '0;
                nbr_recv_bcast[i] = '0;
                used_slots++;
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one event to the shadow state and return its report
    function automatic report_t predict_report(logic [1:0] op_bits, logic [31:0] prev,
                                               logic [31:0] next, logic [15:0] len,
                                               logic fresh, logic [2:0] kind,
                                               logic [4:0] sel, logic [3:0] slot);
        report_t     r;
        logic [63:0] amount;
        logic        bcast;
        int          s;
        count_t      rt;
        count_t      rb;
        r      = '0;
        amount = 64'(len) + 64'(hdr_bytes);
        bcast  = (next == bcast_addr);
        case (op_t'(op_bits))
            OP_LOG_RECV:
            begin
                if (prev != local_addr)
                begin
                    r.was_counted = 1'b1;
                    log_traffic(1'b1, amount, bcast, fresh, kind);
                    s = claim_slot(prev);
                    if (s < 0)
                        r.table_full_drop = 1'b1;
                    else
                    begin
                        nbr_recv[s] = sat_sum(nbr_recv[s], 64'd1);
                        if (bcast)
                            nbr_recv_bcast[s] = sat_sum(nbr_recv_bcast[s], 64'd1);
                    end
                end
            end
            OP_LOG_SEND:
            begin
                r.was_counted = 1'b1;
                log_traffic(1'b0, amount, bcast, fresh, kind);
                if (!bcast)
                begin
                    s = claim_slot(next);
                    if (s < 0)
                        r.table_full_drop = 1'b1;
                    else
                        nbr_sent[s] = sat_sum(nbr_sent[s], 64'd1);
                end
            end
            OP_READ_GLOBAL:
            begin
                if (int'(sel) < NUM_GLOBAL)
                    r.read_value = out_clip(glob_cnt[sel]);
            end
            default:
            begin
                if (int'(slot) < NEIGHBORS && nbr_used[slot])
                begin
                    rt               = nbr_recv[slot];
                    rb               = nbr_recv_bcast[slot];
                    r.entry_valid    = 1'b1;
                    r.entry_address  = nbr_addr[slot];
                    r.sent_unicast   = out_clip(nbr_sent[slot]);
                    r.sent_total     = out_clip(sat_sum(nbr_sent[slot],
                                                        64'(glob_cnt[BCAST_PACKETS_SENT])));
                    r.recv_unicast   = out_clip((rt >= rb) ? rt - rb : '0);
                    r.recv_broadcast = out_clip(rb);
                    r.recv_total     = out_clip(rt);
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Track configuration, score results, then predict new transfers
    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        report_t want;
        if (!rst_n)
        begin
            report_q.delete();
            local_addr  = LOCAL_RESET;
            bcast_addr  = BCAST_RESET;
            hdr_bytes   = '0;
            used_slots  = 0;
            error_count = 0;
            for (int i = 0; i < NUM_GLOBAL; i++)
                glob_cnt[i] = '0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                nbr_used[i]       = 1'b0;
                nbr_addr[i]       = '0;
                nbr_sent[i]       = '0;
                nbr_recv[i]       = '0;
                nbr_recv_bcast[i] = '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_LOCAL_ADDRESS:     local_addr = cfg_data;
                    REG_BROADCAST_ADDRESS: bcast_addr = cfg_data;
                    REG_HEADER_BYTES:      hdr_bytes  = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual read_value %h",
                             $time, read_value);
                    error_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("read_value", want.read_value, read_value);
                    check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid));
                    check_field("entry_address", want.entry_address, entry_address);
                    check_field("sent_unicast", want.sent_unicast, sent_unicast);
                    check_field("sent_total", want.sent_total, sent_total);
                    check_field("recv_unicast", want.recv_unicast, recv_unicast);
                    check_field("recv_broadcast", want.recv_broadcast, recv_broadcast);
                    check_field("recv_total", want.recv_total, recv_total);
                    check_field("was_counted", 32'(want.was_counted), 32'(was_counted));
                    check_field("table_full_drop", 32'(want.table_full_drop),
                                32'(table_full_drop));
                end
            end

            if (in_valid && in_ready)
                report_q.push_back(predict_report(operation, previous_hop, following_hop,
                                                  payload_bytes, is_new, message_kind,
                                                  counter_select, neighbor_slot));
        end
        awaiting   = report_q.size();
        table_fill = used_slots;
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench
    import msgstat_pkg::*;
();

    localparam int POOL_SIZE       = 24;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int IDLE_PCT        = 36;
    localparam int SETTLE_CYCLES   = 12;
    localparam int STALL_LIMIT     = 2000;
    localparam int STEADY_PHASE    = 3;

    localparam logic [31:0] LOCAL_RESET = 32'hFFFF_FFFE;
    localparam logic [31:0] BCAST_RESET = 32'hFFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [31:0] previous_hop;
    logic [31:0] following_hop;
    logic [15:0] payload_bytes;
    logic        is_new;
    logic [2:0]  message_kind;
    logic [4:0]  counter_select;
    logic [3:0]  neighbor_slot;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_value;
    logic        entry_valid;
    logic [31:0] entry_address;
    logic [31:0] sent_unicast;
    logic [31:0] sent_total;
    logic [31:0] recv_unicast;
    logic [31:0] recv_broadcast;
    logic [31:0] recv_total;
    logic        was_counted;
    logic        table_full_drop;

    int          error_count;
    int          awaiting;
    int          table_fill;
    int          quiet_cycles;
    bit          steady;
    logic [31:0] addr_pool [POOL_SIZE];
    logic [31:0] cur_local;
    logic [31:0] cur_bcast;

    message_traffic_statistics uut (.*);

    traffic_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Randomly stall the result channel, except in the steady phase
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one event, idling first at random outside the steady phase, and hold it until the transfer
    task automatic send_event(op_t op, logic [31:0] prev, logic [31:0] next,
                              logic [15:0] len, logic fresh, logic [2:0] kind,
                              logic [4:0] sel, logic [3:0] slot);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid       <= 1'b1;
        operation      <= op;
        previous_hop   <= prev;
        following_hop  <= next;
        payload_bytes  <= len;
        is_new         <= fresh;
        message_kind   <= kind;
        counter_select <= sel;
        neighbor_slot  <= slot;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic read_counter(logic [4:0] sel);
        send_event(OP_READ_GLOBAL, $urandom, $urandom, 16'($urandom), 1'($urandom),
                   3'($urandom), sel, 4'($urandom));
    endtask

    task automatic read_slot(logic [3:0] slot);
        send_event(OP_READ_NEIGHBOR, $urandom, $urandom, 16'($urandom), 1'($urandom),
                   3'($urandom), 5'($urandom), slot);
    endtask

    // Mostly known addresses so the table sees hits, fills up and drops
    task automatic random_event();
        op_t         op;
        logic [31:0] prev;
        logic [31:0] next;
        logic [15:0] len;
        logic [4:0]  sel;
        logic [3:0]  slot;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 35)
            op = OP_LOG_RECV;
        else if (pick < 65)
            op = OP_LOG_SEND;
        else if (pick < 85)
            op = OP_READ_GLOBAL;
        else
            op = OP_READ_NEIGHBOR;

        pick = $urandom_range(99);
        if (pick < 10)
            prev = cur_local;
        else if (pick < 95)
            prev = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else
            prev = $urandom;

        pick = $urandom_range(99);
        if (pick < 25)
            next = cur_bcast;
        else if (pick < 90)
            next = addr_pool[$urandom_range(POOL_SIZE - 1)];
        else
            next = $urandom;

        pick = $urandom_range(99);
        if (pick < 10)
            len = 16'h0000;
        else if (pick < 20)
            len = 16'hFFFF;
        else
            len = 16'($urandom);

        if ($urandom_range(99) < 85)
            sel = 5'($urandom_range(NUM_GLOBAL - 1));
        else
            sel = 5'($urandom);

        // Mostly occupied slots, now and then any slot, empty ones included
        if (op == OP_READ_NEIGHBOR && table_fill > 0 && $urandom_range(99) < 75)
            slot = 4'($urandom_range(table_fill - 1));
        else
            slot = 4'($urandom);

        send_event(op, prev, next, len, 1'($urandom), 3'($urandom), sel, slot);
    endtask

    // Write all three registers on consecutive cycles
    task automatic program_regs(logic [31:0] loc, logic [31:0] bc, logic [31:0] hdr);
        cfg_write <= 1'b1;
        cfg_index <= REG_LOCAL_ADDRESS;
        cfg_data  <= loc;
        @(posedge clk);
        cfg_index <= REG_BROADCAST_ADDRESS;
        cfg_data  <= bc;
        @(posedge clk);
        cfg_index <= REG_HEADER_BYTES;
        cfg_data  <= hdr;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_local = loc;
        cur_bcast = bc;
    endtask

    // Stop sending and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        steady         = 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= REG_LOCAL_ADDRESS;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        operation      <= OP_READ_GLOBAL;
        previous_hop   <= '0;
        following_hop  <= '0;
        payload_bytes  <= '0;
        is_new         <= 1'b0;
        message_kind   <= '0;
        counter_select <= '0;
        neighbor_slot  <= '0;
        cur_local      = LOCAL_RESET;
        cur_bcast      = BCAST_RESET;

        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'h5555_5555;
        addr_pool[2] = 32'hAAAA_AAAA;
        addr_pool[3] = 32'hFFFF_FFFF;
        addr_pool[4] = 32'hFFFF_FFFE;
        for (int i = 5; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty counters and table, out-of-range select, local source,
        // broadcast and unicast traffic both ways, unknown kinds, empty slots
        read_counter(5'd0);
        read_counter(5'd31);
        read_counter(5'd22);
        read_slot(4'd0);
        send_event(OP_LOG_RECV, LOCAL_RESET, addr_pool[1], 16'hFFFF, 1'b1, 3'd0, '0, '0);
        send_event(OP_LOG_RECV, addr_pool[0], BCAST_RESET, 16'hFFFF, 1'b1, 3'd0, '0, '0);
        send_event(OP_LOG_RECV, addr_pool[0], addr_pool[1], 16'h0000, 1'b0, 3'd1, '0, '0);
        send_event(OP_LOG_RECV, addr_pool[3], addr_pool[0], 16'h1234, 1'b1, 3'd2, '0, '0);
        send_event(OP_LOG_SEND, LOCAL_RESET, addr_pool[1], 16'hFFFF, 1'b1, 3'd3, '0, '0);
        send_event(OP_LOG_SEND, addr_pool[0], BCAST_RESET, 16'd100, 1'b0, 3'd4, '0, '0);
        send_event(OP_LOG_SEND, addr_pool[0], addr_pool[2], 16'd7, 1'b1, 3'd5, '0, '0);
        send_event(OP_LOG_SEND, addr_pool[0], addr_pool[1], 16'd8, 1'b0, 3'd7, '0, '0);
        send_event(OP_LOG_RECV, addr_pool[2], BCAST_RESET, 16'd9, 1'b0, 3'd6, '0, '0);
        for (int s = 0; s < 6; s++)
            read_slot(4'(s));
        for (int c = 0; c < 8; c++)
            read_counter(5'(c));
        read_counter(5'(NUM_GLOBAL - 1));
        drain();

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: program_regs(32'h0000_0000, 32'h0000_0000, 32'd255);
                1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd0);
                4: program_regs(LOCAL_RESET, BCAST_RESET, 32'd1);
                default: program_regs(addr_pool[$urandom_range(POOL_SIZE - 1)],
                                      addr_pool[$urandom_range(POOL_SIZE - 1)],
                                      {24'($urandom), 8'($urandom)});
            endcase
            steady = (phase == STEADY_PHASE);
            repeat (ITEMS_PER_PHASE) random_event();
            drain();
        end

        if (error_count == 0 && awaiting == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
design/msgstat_pkg.sv
design/msgstat_ram.sv
design/msgstat_nbr_table.sv
design/message_traffic_statistics.sv
bench/traffic_checker.sv
bench/testbench.sv
